>>> hw/rtl/pls_pkg.sv
// Package for the positional list store.
// Holds operation codes, field widths and the control struct broadcast to the cell row.
// No dependencies.
package pls_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int OP_W   = 2;
    localparam int CNT_OUT_W = 7;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // Command seen by every cell in the cycle an item is accepted
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic                     rd;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

>>> hw/rtl/positional_list_store_top.sv
// Positional list store: ordered list of signed 32-bit entries held in a row of cells.
// Output: result is registered and presented in the cycle after the input transfer.
// Throughput: one item per cycle while m_tready is high; every cell compares and shifts in parallel.
// Reset: rst_n asynchronous, active low; clears the count and output valid.
// Entry contents are not reset and are only read after being written.
// Depends on pls_pkg and pls_cell.
module positional_list_store_top
    import pls_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // operation[1:0], position[8:2], value[40:9], zero pad
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata   // read_value[31:0], count[38:32], is_empty[39],
                                  // error[40], zero pad
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     m_valid_reg;
    logic [47:0]              m_data_reg;
    logic [47:0]              m_data_next;

    logic                     take;
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
    logic [CW-1:0]            pos_ext;
    logic [CW-1:0]            cnt_ext;
    logic [CW-1:0]            cnt_out;
    logic                     pos_nonzero;
    logic                     ins_ok;
    logic                     rem_ok;
    logic                     rd_ok;
    logic                     err;
    cell_ctrl_t               ctrl;

    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic signed [DATA_W-1:0] cell_hit  [DEPTH];
    logic signed [DATA_W-1:0] rd_value;

    // Input handshake: output register frees up when taken
    assign s_tready = !m_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    assign op    = s_tdata[1:0];
    assign pos   = s_tdata[8:2];
    assign value = s_tdata[40:9];

    // Range checks
    assign pos_ext     = CW'(pos);
    assign cnt_ext     = CW'(count_reg);
    assign pos_nonzero = (pos != '0);
    assign ins_ok = (op == OP_INSERT) && (cnt_ext != CW'(DEPTH)) && pos_nonzero
                    && (pos_ext <= cnt_ext + CW'(1));
    assign rem_ok = (op == OP_REMOVE) && pos_nonzero && (pos_ext <= cnt_ext);
    assign rd_ok  = (op == OP_READ) && pos_nonzero && (pos_ext <= cnt_ext);
    assign err    = !(ins_ok || rem_ok || rd_ok);

    // Command broadcast to cells
    always_comb
    begin
        ctrl.ins   = take && ins_ok;
        ctrl.rem   = take && rem_ok;
        ctrl.rd    = take && rd_ok;
        ctrl.pos   = pos;
        ctrl.value = value;
    end

    // Cell row
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_d;
        logic signed [DATA_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = cell_data[i];
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        pls_cell #(
            .INDEX (i),
            .IDX_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .hit_data   (cell_hit[i])
        );
    end

    // Read value: at most one cell drives a nonzero hit
    always_comb
    begin
        rd_value = '0;
        for (int i = 0; i < DEPTH; i++)
            rd_value = rd_value | cell_hit[i];
    end

    // Count update
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins)
            count_next = count_reg + CNT_W'(1);
        else if (ctrl.rem)
            count_next = count_reg - CNT_W'(1);
    end

    assign cnt_out = CW'(count_next);

    // Result packing
    always_comb
    begin
        m_data_next         = '0;
        m_data_next[31:0]   = rd_value;
        m_data_next[38:32]  = cnt_out[CNT_OUT_W-1:0];
        m_data_next[39]     = (count_next == '0);
        m_data_next[40]     = err;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (take)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (take)
            m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> hw/rtl/pls_cell.sv
// One storage cell of the positional list store.
// Holds one entry; shifts from its left or right neighbor on insert/remove.
// Depends on pls_pkg.
module pls_cell
    import pls_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int IDX_W = 7
)
(
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic signed [DATA_W-1:0] left_data,
    input  logic signed [DATA_W-1:0] right_data,
    output logic signed [DATA_W-1:0] data,
    output logic signed [DATA_W-1:0] hit_data
);

    localparam int CW = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic [CW-1:0]            pos_ext;
    logic [CW-1:0]            my_pos;
    logic                     at_pos;
    logic                     past_pos;

    // Compare this cell's 1-based place with the requested position
    assign pos_ext  = CW'(ctrl.pos);
    assign my_pos   = CW'(INDEX + 1);
    assign at_pos   = (pos_ext == my_pos);
    assign past_pos = (pos_ext < my_pos);

    // Next entry: load, shift up from left, shift down from right, or hold
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins)
        begin
            if (at_pos)
                data_next = ctrl.value;
            else if (past_pos)
                data_next = left_data;
        end
        else if (ctrl.rem)
        begin
            if (at_pos || past_pos)
                data_next = right_data;
        end
    end

    // Payload register, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign hit_data = (ctrl.rd && at_pos) ? data_reg : '0;

endmodule
